// File: hdl/mcm_pkg.sv
// Package for the monotonic counter monitor.
// Holds widths, status, mode and register codes, the shared config struct
// and the wrap mask function. No dependencies.
`default_nettype none

package mcm_pkg;

    localparam int CNT_W   = 64;
    localparam int TIME_W  = 63;
    localparam int LOW_W   = 32;
    localparam int TOTAL_W = 32;
    localparam int STAT_W  = 2;
    localparam int MODE_W  = 2;
    localparam int IDX_W   = 1;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_WRAP_REJ  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE     = 2'd2;
    localparam logic [STAT_W-1:0] ST_BACKWARDS = 2'd3;

    localparam logic [MODE_W-1:0] MODE_DIRECT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_W24    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_W32    = 2'd2;

    localparam logic [IDX_W-1:0] REG_MODE  = 1'b0;
    localparam logic [IDX_W-1:0] REG_START = 1'b1;

    localparam logic [LOW_W-1:0]   MASK24    = 32'h00FF_FFFF;
    localparam logic [LOW_W-1:0]   MASK32    = 32'hFFFF_FFFF;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CNT_W-1:0]  start;
    } t_cfg;

    function automatic logic [LOW_W-1:0] f_mode_mask(input logic [MODE_W-1:0] mode);
        logic [LOW_W-1:0] m;
        m = (mode == MODE_W24) ? MASK24 : MASK32;
        return m;
    endfunction

endpackage

`default_nettype wire

// File: hdl/mcm_extend.sv
// Wrap extension stage: turns a raw reading into a 64-bit count.
// Depends on mcm_pkg; keeps the extended count and the last low reading.
`default_nettype none

module mcm_extend
    import mcm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_seed,
    input  wire t_cfg             i_cfg_next,
    input  wire t_cfg             i_cfg,
    input  wire logic             i_vld,
    input  wire logic [CNT_W-1:0] i_raw,
    output logic                  o_rdy,
    output logic                  o_vld,
    input  wire logic             i_rdy_dn,
    output logic                  o_rej,
    output logic [CNT_W-1:0]      o_ext
);

    logic             r_vld;
    logic             r_rej;
    logic [CNT_W-1:0] r_ext_out;
    logic [CNT_W-1:0] r_ext;
    logic [LOW_W-1:0] r_last;

    logic             load;
    logic             wrap_mode;
    logic             wrap_ok;
    logic             n_rej;
    logic [CNT_W-1:0] n_ext;
    logic [LOW_W-1:0] mask;
    logic [LOW_W-1:0] cur;
    logic [LOW_W-1:0] step;
    logic [CNT_W:0]   sum;

    assign o_rdy = !r_vld || i_rdy_dn;
    assign load  = i_vld && o_rdy;

    always_comb begin
        mask      = f_mode_mask(i_cfg.mode);
        cur       = i_raw[LOW_W-1:0] & mask;
        step      = (cur - (r_last & mask)) & mask;
        sum       = {1'b0, r_ext} + {{(CNT_W+1-LOW_W){1'b0}}, step};
        wrap_ok   = (step <= (mask >> 1)) && !sum[CNT_W];
        wrap_mode = 1'b0;
        unique case (i_cfg.mode)
            MODE_DIRECT: begin
                n_rej = 1'b0;
                n_ext = i_raw;
            end
            MODE_W24, MODE_W32: begin
                wrap_mode = 1'b1;
                n_rej     = !wrap_ok;
                n_ext     = sum[CNT_W-1:0];
            end
            default: begin
                n_rej = 1'b1;
                n_ext = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_ext  <= '0;
            r_last <= '0;
        end else begin
            if (o_rdy) begin
                r_vld <= i_vld;
            end
            if (i_seed) begin
                r_ext  <= i_cfg_next.start;
                r_last <= i_cfg_next.start[LOW_W-1:0] & f_mode_mask(i_cfg_next.mode);
            end else if (load && wrap_mode && wrap_ok) begin
                r_ext  <= sum[CNT_W-1:0];
                r_last <= cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rej     <= n_rej;
            r_ext_out <= n_ext;
        end
    end

    assign o_vld = r_vld;
    assign o_rej = r_rej;
    assign o_ext = r_ext_out;

endmodule

`default_nettype wire

// File: hdl/mcm_normalize.sv
// Normalize stage: takes the count relative to the start count and range checks it.
// Depends on mcm_pkg; holds no state beyond its output register.
`default_nettype none

module mcm_normalize
    import mcm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_vld,
    input  wire logic              i_rej,
    input  wire logic [CNT_W-1:0]  i_ext,
    output logic                   o_rdy,
    output logic                   o_vld,
    input  wire logic              i_rdy_dn,
    output logic [STAT_W-1:0]      o_status,
    output logic [TIME_W-1:0]      o_cand,
    output logic [CNT_W-1:0]       o_ext
);

    logic              r_vld;
    logic [STAT_W-1:0] r_status;
    logic [TIME_W-1:0] r_cand;
    logic [CNT_W-1:0]  r_ext;

    logic              load;
    logic [CNT_W:0]    diff;
    logic [STAT_W-1:0] n_status;

    assign o_rdy = !r_vld || i_rdy_dn;
    assign load  = i_vld && o_rdy;

    always_comb begin
        diff = {1'b0, i_ext} - {1'b0, i_cfg.start};
        priority if (i_rej) begin
            n_status = ST_WRAP_REJ;
        end else if (diff[CNT_W] || diff[CNT_W-1]) begin
            n_status = ST_RANGE;
        end else begin
            n_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_status <= n_status;
            r_cand   <= diff[TIME_W-1:0];
            r_ext    <= i_rej ? '0 : i_ext;
        end
    end

    assign o_vld    = r_vld;
    assign o_status = r_status;
    assign o_cand   = r_cand;
    assign o_ext    = r_ext;

endmodule

`default_nettype wire

// File: hdl/mcm_stats.sv
// Statistics stage: monotonic check, step statistics, saturating totals.
// Depends on mcm_pkg; drives the result register.
`default_nettype none

module mcm_stats
    import mcm_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_vld,
    input  wire logic [STAT_W-1:0]  i_status,
    input  wire logic [TIME_W-1:0]  i_cand,
    input  wire logic [CNT_W-1:0]   i_ext,
    output logic                    o_rdy,
    output logic                    o_vld,
    input  wire logic               i_rdy_dn,
    output logic [STAT_W-1:0]       o_status,
    output logic [TIME_W-1:0]       o_norm,
    output logic [CNT_W-1:0]        o_ext,
    output logic [TOTAL_W-1:0]      o_sample_total,
    output logic [TIME_W-1:0]       o_first,
    output logic [TIME_W-1:0]       o_min,
    output logic [TIME_W-1:0]       o_max,
    output logic [TOTAL_W-1:0]      o_regr_total
);

    logic               r_vld;
    logic [TIME_W-1:0]  r_prev;
    logic [TOTAL_W-1:0] r_acc;
    logic [TIME_W-1:0]  r_first;
    logic [TIME_W-1:0]  r_min;
    logic [TIME_W-1:0]  r_max;
    logic [TOTAL_W-1:0] r_regr;

    logic [STAT_W-1:0]  r_out_status;
    logic [TIME_W-1:0]  r_out_norm;
    logic [CNT_W-1:0]   r_out_ext;
    logic [TOTAL_W-1:0] r_out_acc;
    logic [TIME_W-1:0]  r_out_first;
    logic [TIME_W-1:0]  r_out_min;
    logic [TIME_W-1:0]  r_out_max;
    logic [TOTAL_W-1:0] r_out_regr;

    logic               load;
    logic [TIME_W-1:0]  d;
    logic [STAT_W-1:0]  n_status;
    logic [TIME_W-1:0]  n_prev;
    logic [TOTAL_W-1:0] n_acc;
    logic [TIME_W-1:0]  n_first;
    logic [TIME_W-1:0]  n_min;
    logic [TIME_W-1:0]  n_max;
    logic [TOTAL_W-1:0] n_regr;
    logic [TIME_W-1:0]  n_norm;

    assign o_rdy = !r_vld || i_rdy_dn;
    assign load  = i_vld && o_rdy;

    always_comb begin
        d        = i_cand - r_prev;
        n_status = i_status;
        n_prev   = r_prev;
        n_acc    = r_acc;
        n_first  = r_first;
        n_min    = r_min;
        n_max    = r_max;
        n_regr   = r_regr;
        n_norm   = '0;
        if (i_status == ST_OK) begin
            if (r_acc != '0) begin
                if (i_cand < r_prev) begin
                    n_status = ST_BACKWARDS;
                end else begin
                    if (r_acc == TOTAL_W'(1) || d < r_min) begin
                        n_min = d;
                    end
                    if (d > r_max) begin
                        n_max = d;
                    end
                end
            end else begin
                n_first = i_cand;
                n_min   = '0;
                n_max   = '0;
            end
        end
        if (n_status == ST_OK) begin
            n_prev = i_cand;
            n_norm = i_cand;
            if (r_acc != TOTAL_MAX) begin
                n_acc = r_acc + TOTAL_W'(1);
            end
        end else if (r_regr != TOTAL_MAX) begin
            n_regr = r_regr + TOTAL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= 1'b0;
            r_prev  <= '0;
            r_acc   <= '0;
            r_first <= '0;
            r_min   <= '0;
            r_max   <= '0;
            r_regr  <= '0;
        end else begin
            if (o_rdy) begin
                r_vld <= i_vld;
            end
            if (load) begin
                r_prev  <= n_prev;
                r_acc   <= n_acc;
                r_first <= n_first;
                r_min   <= n_min;
                r_max   <= n_max;
                r_regr  <= n_regr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_status <= n_status;
            r_out_norm   <= n_norm;
            r_out_ext    <= i_ext;
            r_out_acc    <= n_acc;
            r_out_first  <= n_first;
            r_out_min    <= n_min;
            r_out_max    <= n_max;
            r_out_regr   <= n_regr;
        end
    end

    assign o_vld          = r_vld;
    assign o_status       = r_out_status;
    assign o_norm         = r_out_norm;
    assign o_ext          = r_out_ext;
    assign o_sample_total = r_out_acc;
    assign o_first        = r_out_first;
    assign o_min          = r_out_min;
    assign o_max          = r_out_max;
    assign o_regr_total   = r_out_regr;

endmodule

`default_nettype wire

// File: hdl/monotonic_counter_monitor.sv
// Top level of the monotonic counter monitor: config registers and three stages.
// Depends on mcm_pkg, mcm_extend, mcm_normalize and mcm_stats.
//
//  channel  | signals                               | direction
//  ---------+---------------------------------------+----------
//  input    | i_in_valid / o_in_ready, raw reading  | in
//  result   | o_out_valid / i_out_ready, 8 fields   | out
//  config   | i_cfg_we, i_cfg_idx, i_cfg_data       | in
//
// One word is accepted per cycle while the result side is not stalled; a result passes the extend,
// normalize and stats output registers in turn. The rate is set by the state loops in the extend and stats stages.
// Each stage holds its word while the stage after it is full and stalled.
// Synchronous active-low reset clears all valid bits, the config, extend state and statistics, not the output data.
`default_nettype none

module monotonic_counter_monitor
    import mcm_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [IDX_W-1:0]   i_cfg_idx,
    input  wire logic [CNT_W-1:0]   i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [CNT_W-1:0]   i_raw_reading,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [STAT_W-1:0]       o_status,
    output logic [TIME_W-1:0]       o_normalized_time,
    output logic [CNT_W-1:0]        o_extended_raw,
    output logic [TOTAL_W-1:0]      o_sample_total,
    output logic [TIME_W-1:0]       o_first_time,
    output logic [TIME_W-1:0]       o_min_step,
    output logic [TIME_W-1:0]       o_max_step,
    output logic [TOTAL_W-1:0]      o_regression_total
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    logic              ext_vld;
    logic              ext_rej;
    logic [CNT_W-1:0]  ext_val;
    logic              norm_rdy;
    logic              norm_vld;
    logic [STAT_W-1:0] norm_status;
    logic [TIME_W-1:0] norm_cand;
    logic [CNT_W-1:0]  norm_ext;
    logic              stats_rdy;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MODE:  n_cfg.mode  = i_cfg_data[MODE_W-1:0];
                REG_START: n_cfg.start = i_cfg_data;
                default:   n_cfg       = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    mcm_extend u_extend (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_seed     (i_cfg_we),
        .i_cfg_next (n_cfg),
        .i_cfg      (r_cfg),
        .i_vld      (i_in_valid),
        .i_raw      (i_raw_reading),
        .o_rdy      (o_in_ready),
        .o_vld      (ext_vld),
        .i_rdy_dn   (norm_rdy),
        .o_rej      (ext_rej),
        .o_ext      (ext_val)
    );

    mcm_normalize u_normalize (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_vld    (ext_vld),
        .i_rej    (ext_rej),
        .i_ext    (ext_val),
        .o_rdy    (norm_rdy),
        .o_vld    (norm_vld),
        .i_rdy_dn (stats_rdy),
        .o_status (norm_status),
        .o_cand   (norm_cand),
        .o_ext    (norm_ext)
    );

    mcm_stats u_stats (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_vld          (norm_vld),
        .i_status       (norm_status),
        .i_cand         (norm_cand),
        .i_ext          (norm_ext),
        .o_rdy          (stats_rdy),
        .o_vld          (o_out_valid),
        .i_rdy_dn       (i_out_ready),
        .o_status       (o_status),
        .o_norm         (o_normalized_time),
        .o_ext          (o_extended_raw),
        .o_sample_total (o_sample_total),
        .o_first        (o_first_time),
        .o_min          (o_min_step),
        .o_max          (o_max_step),
        .o_regr_total   (o_regression_total)
    );

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for monotonic_counter_monitor: a stimulus table, then random
// phases of counter readings, each report checked against an in-bench monitor model.
// Depends on mcm_pkg and the monotonic_counter_monitor RTL.

module tb_top
    import mcm_pkg::*;
;

    localparam int unsigned CYCLE_LIMIT  = 100000;
    localparam int unsigned RANDOM_ITEMS = 800;
    localparam int unsigned LONG_HOLD    = 60;
    localparam int unsigned N_DIRECTED   = 24;

    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

    typedef enum logic {ROW_WORD, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic [IDX_W-1:0]  idx;
        logic [CNT_W-1:0]  value;
        logic              typed;
        logic [STAT_W-1:0] want;
    } t_stim_row;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [TIME_W-1:0]  norm_time;
        logic [CNT_W-1:0]   ext_raw;
        logic [TOTAL_W-1:0] samples;
        logic [TIME_W-1:0]  first_time;
        logic [TIME_W-1:0]  step_min;
        logic [TIME_W-1:0]  step_max;
        logic [TOTAL_W-1:0] regressions;
    } t_report;

    localparam t_stim_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{ROW_WORD, REG_MODE,  64'd0,                   1'b1, ST_OK},
        '{ROW_WORD, REG_MODE,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_RANGE},
        '{ROW_WORD, REG_MODE,  64'h8000_0000_0000_0000, 1'b1, ST_RANGE},
        '{ROW_WORD, REG_MODE,  64'd1000,                1'b1, ST_OK},
        '{ROW_WORD, REG_MODE,  64'd999,                 1'b1, ST_BACKWARDS},
        '{ROW_WORD, REG_MODE,  64'd1000,                1'b1, ST_OK},
        '{ROW_CFG,  REG_START, 64'd5000,                1'b0, ST_OK},
        '{ROW_WORD, REG_MODE,  64'd4999,                1'b1, ST_RANGE},
        '{ROW_WORD, REG_MODE,  64'd7000,                1'b1, ST_OK},
        '{ROW_CFG,  REG_MODE,  64'(MODE_W24),           1'b0, ST_OK},
        '{ROW_WORD, REG_MODE,  64'hFFFF_FFFF_FF80_1388, 1'b1, ST_WRAP_REJ},
        '{ROW_WORD, REG_MODE,  64'hA5A5_A5A5_A580_1387, 1'b1, ST_OK},
        '{ROW_WORD, REG_MODE,  64'h0000_0000_0000_1386, 1'b1, ST_OK},
        '{ROW_CFG,  REG_MODE,  64'(MODE_W32),           1'b0, ST_OK},
        '{ROW_WORD, REG_MODE,  64'hFFFF_FFFF_0000_1388, 1'b1, ST_BACKWARDS},
        '{ROW_WORD, REG_MODE,  64'h0000_0000_8000_1388, 1'b1, ST_WRAP_REJ},
        '{ROW_WORD, REG_MODE,  64'h8000_0000_0100_1388, 1'b1, ST_OK},
        '{ROW_CFG,  REG_START, 64'hFFFF_FFFF_FFFF_FFF0, 1'b0, ST_OK},
        '{ROW_WORD, REG_MODE,  64'h0000_0000_0000_0010, 1'b1, ST_WRAP_REJ},
        '{ROW_CFG,  REG_MODE,  64'(MODE_NONE),          1'b0, ST_OK},
        '{ROW_WORD, REG_MODE,  64'h5555_5555_5555_5555, 1'b1, ST_WRAP_REJ},
        '{ROW_CFG,  REG_MODE,  64'(MODE_DIRECT),        1'b0, ST_OK},
        '{ROW_WORD, REG_MODE,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_BACKWARDS},
        '{ROW_CFG,  REG_START, 64'd0,                   1'b0, ST_OK}
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [IDX_W-1:0]   i_cfg_idx = '0;
    logic [CNT_W-1:0]   i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [CNT_W-1:0]   i_raw_reading = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [STAT_W-1:0]  o_status;
    logic [TIME_W-1:0]  o_normalized_time;
    logic [CNT_W-1:0]   o_extended_raw;
    logic [TOTAL_W-1:0] o_sample_total;
    logic [TIME_W-1:0]  o_first_time;
    logic [TIME_W-1:0]  o_min_step;
    logic [TIME_W-1:0]  o_max_step;
    logic [TOTAL_W-1:0] o_regression_total;

    // monitor model state
    logic [MODE_W-1:0]  cur_mode = MODE_DIRECT;
    logic [CNT_W-1:0]   cur_start = '0;
    logic [CNT_W-1:0]   track_count = '0;
    logic [LOW_W-1:0]   track_low = '0;
    logic [CNT_W-1:0]   last_time = '0;
    logic [CNT_W-1:0]   origin_time = '0;
    logic [CNT_W-1:0]   step_lo = '0;
    logic [CNT_W-1:0]   step_hi = '0;
    logic [TOTAL_W-1:0] ok_count = '0;
    logic [TOTAL_W-1:0] bad_count = '0;

    t_report     awaited_reports[$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned idle_pct = 23;
    bit          hold_request = 1'b0;

    monotonic_counter_monitor dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_raw_reading      (i_raw_reading),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_status           (o_status),
        .o_normalized_time  (o_normalized_time),
        .o_extended_raw     (o_extended_raw),
        .o_sample_total     (o_sample_total),
        .o_first_time       (o_first_time),
        .o_min_step         (o_min_step),
        .o_max_step         (o_max_step),
        .o_regression_total (o_regression_total)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("tb_top: done, errors");
        $finish;
    end

    function automatic logic [CNT_W-1:0] wrap_span();
        return (cur_mode == MODE_W24) ? 64'h00FF_FFFF : 64'hFFFF_FFFF;
    endfunction

    function automatic void apply_register(input logic [IDX_W-1:0] idx,
                                           input logic [CNT_W-1:0] data);
        if (idx == REG_MODE) begin
            cur_mode = data[MODE_W-1:0];
        end else begin
            cur_start = data;
        end
        track_count = cur_start;
        track_low   = cur_start[LOW_W-1:0] & LOW_W'(wrap_span());
    endfunction

    function automatic t_report advance_monitor(input logic [CNT_W-1:0] raw);
        t_report           r;
        logic [CNT_W-1:0]  span, low, delta, ext, cand, gap;
        logic [STAT_W-1:0] st;
        st   = ST_OK;
        ext  = '0;
        cand = '0;
        if (cur_mode == MODE_DIRECT) begin
            ext = raw;
        end else if (cur_mode == MODE_W24 || cur_mode == MODE_W32) begin
            span  = wrap_span();
            low   = raw & span;
            delta = (low - ({32'd0, track_low} & span)) & span;
            if (delta > (span >> 1) || track_count > ~delta) begin
                st = ST_WRAP_REJ;
            end else begin
                track_count = track_count + delta;
                track_low   = low[LOW_W-1:0];
                ext         = track_count;
            end
        end else begin
            st = ST_WRAP_REJ;
        end
        if (st == ST_OK) begin
            if (ext < cur_start || (ext - cur_start) > 64'h7FFF_FFFF_FFFF_FFFF) begin
                st = ST_RANGE;
            end else begin
                cand = ext - cur_start;
                if (ok_count != 0) begin
                    if (cand < last_time) begin
                        st = ST_BACKWARDS;
                    end else begin
                        gap = cand - last_time;
                        if (ok_count == 1 || gap < step_lo) step_lo = gap;
                        if (gap > step_hi) step_hi = gap;
                    end
                end else begin
                    origin_time = cand;
                    step_lo     = '0;
                    step_hi     = '0;
                end
                if (st == ST_OK) begin
                    last_time = cand;
                    if (ok_count != TOTAL_MAX) ok_count = ok_count + 1;
                end
            end
        end
        if (st != ST_OK && bad_count != TOTAL_MAX) bad_count = bad_count + 1;
        r.status      = st;
        r.norm_time   = (st == ST_OK) ? cand[TIME_W-1:0] : '0;
        r.ext_raw     = (st == ST_WRAP_REJ) ? '0 : ext;
        r.samples     = ok_count;
        r.first_time  = origin_time[TIME_W-1:0];
        r.step_min    = step_lo[TIME_W-1:0];
        r.step_max    = step_hi[TIME_W-1:0];
        r.regressions = bad_count;
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] draw_step();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return 64'($urandom_range(0, 255));
            6, 7, 8:          return 64'($urandom_range(0, 65535));
            default:          return 64'($urandom_range(0, 32'h007F_FFFF));
        endcase
    endfunction

    // well-formed readings mostly, built from the model state so they keep climbing
    function automatic logic [CNT_W-1:0] next_reading();
        logic [CNT_W-1:0] noise, span, half, ahead, gap;
        int unsigned      pick;
        pick  = $urandom_range(0, 99);
        noise = {$urandom, $urandom};
        if (pick < 10 || cur_mode == MODE_NONE) return noise;
        if (cur_mode == MODE_DIRECT) begin
            gap = draw_step();
            if (pick < 16) return cur_start + last_time - gap - 1;
            return cur_start + last_time + gap;
        end
        span  = wrap_span();
        half  = span >> 1;
        ahead = track_count - cur_start;
        if (ahead < last_time) begin
            gap = ((last_time - ahead) > half) ? half : (last_time - ahead);
        end else if (pick < 12) begin
            gap = half + 1 + 64'($urandom_range(0, 1000));
        end else if (pick < 14) begin
            gap = span - 64'($urandom_range(0, 255));
        end else if (pick < 16 && cur_mode == MODE_W24) begin
            gap = half;
        end else begin
            gap = draw_step();
        end
        return (noise & ~span) | (({32'd0, track_low} + gap) & span);
    endfunction

    task automatic send_reading(input logic [CNT_W-1:0] raw, input logic typed,
                                input logic [STAT_W-1:0] want);
        t_report w;
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_raw_reading <= raw;
        do @(posedge i_clk); while (!o_in_ready);
        w = advance_monitor(raw);
        if (typed) w.status = want;
        awaited_reports.push_back(w);
        @(negedge i_clk);
    endtask

    // drain, let the pipe settle, then write
    task automatic write_register(input logic [IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
        i_in_valid <= 1'b0;
        while (awaited_reports.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        apply_register(idx, data);
    endtask

    function automatic void report_field(input string name, input logic [CNT_W-1:0] want,
                                         input logic [CNT_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    task automatic check_report();
        t_report want;
        if (awaited_reports.size() == 0) begin
            $display("%0t: report with none pending, status %0d extended %h",
                     $time, o_status, o_extended_raw);
            error_count++;
        end else begin
            want = awaited_reports.pop_front();
            report_field("status",           64'(want.status),      64'(o_status));
            report_field("normalized_time",  64'(want.norm_time),   64'(o_normalized_time));
            report_field("extended_raw",     want.ext_raw,          o_extended_raw);
            report_field("sample_total",     64'(want.samples),     64'(o_sample_total));
            report_field("first_time",       64'(want.first_time),  64'(o_first_time));
            report_field("min_step",         64'(want.step_min),    64'(o_min_step));
            report_field("max_step",         64'(want.step_max),    64'(o_max_step));
            report_field("regression_total", 64'(want.regressions), 64'(o_regression_total));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) check_report();
    end

    initial begin : result_sink
        int unsigned hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold = LONG_HOLD;
            end
            if (hold > 0) begin
                hold--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= idle_pct);
            end
        end
    end

    initial begin : stimulus
        logic [CNT_W-1:0]  noise;
        logic [MODE_W-1:0] next_mode;
        int unsigned       choice, len, phase, sent;
        phase = 0;
        sent  = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int k = 0; k < N_DIRECTED; k++) begin
            if (DIRECTED_ROWS[k].kind == ROW_CFG) begin
                write_register(DIRECTED_ROWS[k].idx, DIRECTED_ROWS[k].value);
            end else begin
                send_reading(DIRECTED_ROWS[k].value, DIRECTED_ROWS[k].typed,
                             DIRECTED_ROWS[k].want);
            end
        end

        while (sent < RANDOM_ITEMS) begin
            noise  = {$urandom, $urandom};
            choice = $urandom_range(0, 15);
            if (choice < 5) begin
                next_mode = MODE_DIRECT;
            end else if (choice < 10) begin
                next_mode = MODE_W24;
            end else if (choice < 15) begin
                next_mode = MODE_W32;
            end else begin
                next_mode = MODE_NONE;
            end
            write_register(REG_MODE, {noise[CNT_W-1:MODE_W], next_mode});
            case ($urandom_range(0, 7))
                0:       write_register(REG_START, '0);
                1:       write_register(REG_START, ~64'($urandom_range(0, 1 << 20)));
                2:       ;
                default: write_register(REG_START, {$urandom, $urandom});
            endcase
            idle_pct = (phase == 3) ? 0 : 23;
            if (phase == 1) hold_request = 1'b1;
            len = $urandom_range(20, 70);
            repeat (len) begin
                send_reading(next_reading(), 1'b0, ST_OK);
                sent++;
            end
            phase++;
        end

        // exact half-range step at 32 bits, then the top of normalised time
        idle_pct = 23;
        write_register(REG_MODE, 64'(MODE_W32));
        write_register(REG_START, '0);
        send_reading(64'h0000_0000_7FFF_FFFF, 1'b0, ST_OK);
        write_register(REG_MODE, 64'(MODE_DIRECT));
        send_reading(64'h7FFF_FFFF_FFFF_FFFF, 1'b0, ST_OK);
        send_reading(64'h7FFF_FFFF_FFFF_FFFF, 1'b0, ST_OK);

        i_in_valid <= 1'b0;
        while (awaited_reports.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
